// File: hw/rtl/chbd_pkg.sv
// Shared types and constants for the canonical Huffman block decoder.
// No dependencies; every other file refers to it by scoped names.
package chbd_pkg;

  localparam int BYTE_W    = 8;
  localparam int SYM_W     = 4;
  localparam int LEN_W     = 4;
  localparam int CODE_W    = 15;
  localparam int TABLE_W   = 64;
  localparam int CFG_IDX_W = 2;
  localparam int BITCNT_W  = 4;
  localparam int BLEN_W    = 8;
  localparam int SCNT_W    = 5;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_TABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH_TABLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_COUNT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LENGTH = 2'd3;

  // One canonical code entry as seen by the bit matcher
  typedef struct packed {
    logic              en;
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code;
    logic [SYM_W-1:0]  sym;
  } entry_t;

  // Head of the byte queue toward the decoder
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
  } qhead_t;

endpackage

// File: hw/rtl/canonical_huffman_block_decoder.sv
// Top level of the canonical Huffman block decoder: byte queue, code builder,
// bit-serial decoder. Depends on chbd_pkg, chbd_front, chbd_table, chbd_back.
//
//   channel   direction  item
//   s_axis    in         one coded byte, msb first
//   m_axis    out        one decoded symbol or one overflow error
//   cfg       in         one register write (index 0..3, 64-bit data)
//
// The decoder consumes one code bit per cycle while its result slot is free and
// drops the rest of a byte when a block ends or a prefix overflows; the next
// queued byte loads in the same cycle the last bit is used. The queue accepts
// bytes until full while the decoder works. After reset and after every register
// write the code builder walks the table one entry a cycle; bytes wait queued.
// A held result stalls the decoder only; the queue still fills.
module canonical_huffman_block_decoder #(
  parameter int TABLE_ENTRIES = 16,
  parameter int MAX_CODE_BITS = 15
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [chbd_pkg::BYTE_W-1:0]      s_axis_tdata,  // [7:0] code_byte
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [chbd_pkg::BYTE_W-1:0]      m_axis_tdata,  // [3:0] symbol, [7:4] zero
  output logic                            m_axis_tlast,  // last_in_block
  output logic                            m_axis_tuser,  // [0] error
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [chbd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [chbd_pkg::TABLE_W-1:0]     cfg_data
);

  chbd_pkg::qhead_t                       head;
  logic                                   pop;
  chbd_pkg::entry_t [TABLE_ENTRIES-1:0]   entries;
  logic [chbd_pkg::BLEN_W-1:0]            block_length;
  logic                                   table_ready;
  logic [chbd_pkg::SYM_W-1:0]             out_symbol;

  assign cfg_ready    = 1'b1;
  assign m_axis_tdata = {{(chbd_pkg::BYTE_W - chbd_pkg::SYM_W){1'b0}}, out_symbol};

  chbd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .head          (head),
    .pop           (pop)
  );

  chbd_table #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_table (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .entries      (entries),
    .block_length (block_length),
    .ready        (table_ready)
  );

  chbd_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .pop          (pop),
    .table_ready  (table_ready),
    .entries      (entries),
    .block_length (block_length),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_symbol   (out_symbol),
    .out_last     (m_axis_tlast),
    .out_error    (m_axis_tuser)
  );

endmodule

// File: hw/rtl/chbd_front.sv
// Input side: two-entry byte queue between the stream slave and the decoder.
// Depends on chbd_pkg.
module chbd_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [chbd_pkg::BYTE_W-1:0] s_axis_tdata,
  output chbd_pkg::qhead_t           head,
  input  logic                       pop
);

  logic [chbd_pkg::BYTE_W-1:0] mem [2];
  logic                        wr_ptr;
  logic                        rd_ptr;
  logic [1:0]                  count;
  logic                        push;

  assign s_axis_tready = (count != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign head.valid    = (count != 2'd0);
  assign head.data     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= s_axis_tdata;
    end
  end

endmodule

// File: hw/rtl/chbd_table.sv
// Configuration registers and the canonical code builder, one entry per cycle between writes.
// Depends on chbd_pkg.
module chbd_table #(
  parameter int TABLE_ENTRIES = 16,
  parameter int MAX_CODE_BITS = 15
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [chbd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [chbd_pkg::TABLE_W-1:0]   cfg_data,
  output chbd_pkg::entry_t [TABLE_ENTRIES-1:0] entries,
  output logic [chbd_pkg::BLEN_W-1:0]    block_length,
  output logic                          ready
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic [chbd_pkg::TABLE_W-1:0] symbol_table;
  logic [chbd_pkg::TABLE_W-1:0] length_table;
  logic [chbd_pkg::SCNT_W-1:0]  symbol_count;

  logic                         building;
  logic [IDX_W-1:0]             idx;
  logic [15:0]                  code;
  logic [chbd_pkg::LEN_W-1:0]   prev;

  logic [chbd_pkg::LEN_W-1:0]   len_arr [TABLE_ENTRIES];
  logic                         ent_en   [TABLE_ENTRIES];
  logic [chbd_pkg::CODE_W-1:0]  ent_code [TABLE_ENTRIES];

  logic [chbd_pkg::LEN_W-1:0]   el;
  logic [15:0]                  shifted;
  logic [15:0]                  mask;
  logic [15:0]                  masked;
  logic [chbd_pkg::SCNT_W-1:0]  used;

  assign ready = !building;

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_ent
    assign len_arr[g]      = length_table[chbd_pkg::LEN_W*g +: chbd_pkg::LEN_W];
    assign entries[g].en   = ent_en[g];
    assign entries[g].len  = len_arr[g];
    assign entries[g].code = ent_code[g];
    assign entries[g].sym  = symbol_table[chbd_pkg::SYM_W*g +: chbd_pkg::SYM_W];
  end

  always_comb begin
    el   = len_arr[idx];
    used = (symbol_count > chbd_pkg::SCNT_W'(TABLE_ENTRIES)) ?
           chbd_pkg::SCNT_W'(TABLE_ENTRIES) : symbol_count;
    // shift only when the length grows past a nonzero previous length
    shifted = (prev != '0 && el > prev) ? (code << (el - prev)) : code;
    mask    = (16'd1 << el) - 16'd1;
    masked  = shifted & mask;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_table <= '0;
      length_table <= '0;
      symbol_count <= 5'd16;
      block_length <= 8'd32;
      building     <= 1'b1;
      idx          <= '0;
      code         <= '0;
      prev         <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        chbd_pkg::REG_SYMBOL_TABLE: symbol_table <= cfg_data;
        chbd_pkg::REG_LENGTH_TABLE: length_table <= cfg_data;
        chbd_pkg::REG_SYMBOL_COUNT: symbol_count <= cfg_data[chbd_pkg::SCNT_W-1:0];
        chbd_pkg::REG_BLOCK_LENGTH: block_length <= cfg_data[chbd_pkg::BLEN_W-1:0];
        default: ;
      endcase
      // restart the build from the first entry
      building <= 1'b1;
      idx      <= '0;
      code     <= '0;
      prev     <= '0;
    end else if (building) begin
      code <= shifted + 16'd1;
      prev <= el;
      idx  <= idx + IDX_W'(1);
      if (idx == IDX_W'(TABLE_ENTRIES - 1)) begin
        building <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        ent_en[i] <= 1'b0;
      end
    end else if (building && !cfg_we) begin
      ent_en[idx] <= (el != '0) && (el <= chbd_pkg::LEN_W'(MAX_CODE_BITS)) &&
                     (chbd_pkg::SCNT_W'(idx) < used);
    end
  end

  always_ff @(posedge clk) begin
    if (building) begin
      ent_code[idx] <= masked[chbd_pkg::CODE_W-1:0];
    end
  end

endmodule

// File: hw/rtl/chbd_back.sv
// Bit-serial decoder: one code bit a cycle against all entries, result register; a held result stalls it.
// Depends on chbd_pkg.
module chbd_back #(
  parameter int TABLE_ENTRIES = 16,
  parameter int MAX_CODE_BITS = 15
) (
  input  logic                              clk,
  input  logic                              rst,
  input  chbd_pkg::qhead_t                  head,
  output logic                              pop,
  input  logic                              table_ready,
  input  chbd_pkg::entry_t [TABLE_ENTRIES-1:0] entries,
  input  logic [chbd_pkg::BLEN_W-1:0]        block_length,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [chbd_pkg::SYM_W-1:0]         out_symbol,
  output logic                              out_last,
  output logic                              out_error
);

  localparam int PW = MAX_CODE_BITS;

  logic [chbd_pkg::BYTE_W-1:0]   cur;
  logic [chbd_pkg::BITCNT_W-1:0] bits_left;
  logic [PW-1:0]                 prefix;
  logic [chbd_pkg::LEN_W-1:0]    plen;
  logic [chbd_pkg::BLEN_W-1:0]   done;

  logic [PW-1:0]                 prefix_new;
  logic [chbd_pkg::LEN_W-1:0]    plen_new;
  logic                          hit;
  logic [chbd_pkg::SYM_W-1:0]    hit_sym;
  logic                          overflow;
  logic [chbd_pkg::BLEN_W:0]     count;
  logic [chbd_pkg::BLEN_W:0]     limit;
  logic                          is_last;
  logic                          slot_free;
  logic                          active;
  logic                          step;
  logic                          ending;
  logic                          load;

  always_comb begin
    prefix_new = {prefix[PW-2:0], cur[chbd_pkg::BYTE_W-1]};
    plen_new   = plen + 4'd1;
    hit        = 1'b0;
    hit_sym    = '0;
    // later entries override earlier ones on duplicate codes
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (entries[i].en && entries[i].len == plen_new &&
          entries[i].code == chbd_pkg::CODE_W'(prefix_new)) begin
        hit     = 1'b1;
        hit_sym = entries[i].sym;
      end
    end
    overflow  = !hit && (plen_new >= chbd_pkg::LEN_W'(MAX_CODE_BITS));
    count     = {1'b0, done} + 9'd1;
    limit     = (block_length == '0) ? 9'd256 : {1'b0, block_length};
    is_last   = hit && (count >= limit);
    slot_free = !out_valid || out_ready;
    active    = (bits_left != '0);
    step      = active && slot_free;
    ending    = is_last || overflow || (bits_left == 4'd1);
    load      = head.valid && table_ready && (!active || (step && ending));
  end

  assign pop = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      bits_left <= '0;
      prefix    <= '0;
      plen      <= '0;
      done      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (slot_free) begin
        out_valid <= step && (hit || overflow);
      end
      if (step) begin
        if (hit) begin
          prefix <= '0;
          plen   <= '0;
          done   <= is_last ? '0 : count[chbd_pkg::BLEN_W-1:0];
        end else if (overflow) begin
          prefix <= '0;
          plen   <= '0;
          done   <= '0;
        end else begin
          prefix <= prefix_new;
          plen   <= plen_new;
        end
      end
      // drop the rest of the byte when a block ends or a prefix overflows
      if (load) begin
        bits_left <= 4'd8;
      end else if (step) begin
        bits_left <= ending ? '0 : bits_left - 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= head.data;
    end else if (step) begin
      cur <= {cur[chbd_pkg::BYTE_W-2:0], 1'b0};
    end
    if (step && (hit || overflow)) begin
      out_symbol <= hit ? hit_sym : '0;
      out_last   <= is_last;
      out_error  <= overflow;
    end
  end

endmodule
